// ===== hw/rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes of the circular deque: payload structs, operation
// and status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Default depth of the element store.
    localparam int DEF_STORE_DEPTH = 128;

    // Element width, fixed by the payload fields.
    localparam int VALUE_W = 32;

    // Width of the size register and its value after reset.
    localparam int          SIZE_W     = 8;
    localparam logic [7:0]  SIZE_RESET = 8'd128;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [1:0] MODE_PUSH_REAR  = 2'd1;
    localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [1:0] MODE_POP_REAR   = 2'd3;

    // Status codes returned with each result.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // One request.
    typedef struct packed {
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] removed_value;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] rear_value;
        logic                      is_empty;
        logic                      is_full;
    } t_out_item;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the incoming request
        logic exec;       // perform the operation on indices and store
        logic read_done;  // store read data is valid, refresh the cached end
        logic load_out;   // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;  // the pending pop leaves elements, new end must be read
    } t_stat;

endpackage

// ===== hw/rtl/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer of the circular deque: accepts a request, steps the datapath
// through execute, optional store read and result load, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // The result register can take a new result when empty or being drained.
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_read ? S_READ : S_OUT;
            end
            S_READ: begin
                o_cmd.read_done = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when the result is taken.
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/cdq_dpath.sv =====
// ----------------------------------------------------------------------------
// cdq_dpath
// Datapath of the circular deque: size register, front and rear indices,
// empty mark, cached front and rear elements, element store and the
// result register.
// ----------------------------------------------------------------------------
module cdq_dpath
    import cdq_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_in_data,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output t_out_item         o_out_data
);

    localparam int IW = $clog2(STORE_DEPTH);
    localparam int SW = (IW + 1 > SIZE_W) ? IW + 1 : SIZE_W;
    localparam logic [SW-1:0] DEPTH_S = SW'(STORE_DEPTH);

    // Control state.
    logic [SIZE_W-1:0] r_size;
    logic [IW-1:0]     r_front, n_front;
    logic [IW-1:0]     r_rear, n_rear;
    logic              r_empty, n_empty;

    // Payload state.
    logic [1:0]         r_mode;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] r_front_val, n_front_val;
    logic [VALUE_W-1:0] r_rear_val, n_rear_val;
    logic [1:0]         r_status, n_status;
    logic [VALUE_W-1:0] r_removed, n_removed;
    logic               r_pop_front;
    t_out_item          r_out;

    // Store ports.
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [IW-1:0]      w_raddr;
    logic [VALUE_W-1:0] w_rdata;

    // Index arithmetic.
    logic [SW-1:0] w_size_ext;
    logic [SW-1:0] w_last_ext;
    logic [IW-1:0] w_last;
    logic [IW-1:0] w_front_fwd, w_front_back, w_rear_fwd, w_rear_back;
    logic          w_full;
    logic          w_need_read;

    // Slots in use, held to 1..STORE_DEPTH; w_last is the highest used slot.
    always_comb begin
        w_size_ext = SW'(r_size);
        if (w_size_ext == '0) begin
            w_last_ext = '0;
        end else if (w_size_ext > DEPTH_S) begin
            w_last_ext = DEPTH_S - 1'b1;
        end else begin
            w_last_ext = w_size_ext - 1'b1;
        end
        w_last = w_last_ext[IW-1:0];
    end

    // Circular steps; an index at or past the last slot wraps to zero.
    assign w_front_fwd  = (r_front >= w_last) ? '0 : r_front + 1'b1;
    assign w_rear_fwd   = (r_rear  >= w_last) ? '0 : r_rear  + 1'b1;
    assign w_front_back = (r_front == '0) ? w_last : r_front - 1'b1;
    assign w_rear_back  = (r_rear  == '0) ? w_last : r_rear  - 1'b1;

    assign w_full = !r_empty && (w_rear_fwd == r_front);

    // Operation on the latched request.
    always_comb begin
        n_front     = r_front;
        n_rear      = r_rear;
        n_empty     = r_empty;
        n_front_val = r_front_val;
        n_rear_val  = r_rear_val;
        n_status    = ST_DONE;
        n_removed   = '0;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_raddr     = '0;
        w_need_read = 1'b0;
        case (r_mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                end else if (r_empty) begin
                    // The first element always goes to slot zero.
                    n_front     = '0;
                    n_rear      = '0;
                    n_empty     = 1'b0;
                    w_we        = 1'b1;
                    n_front_val = r_value;
                    n_rear_val  = r_value;
                end else if (r_mode == MODE_PUSH_FRONT) begin
                    n_front     = w_front_back;
                    w_we        = 1'b1;
                    w_waddr     = w_front_back;
                    n_front_val = r_value;
                    // After a size change the new slot may be the rear slot.
                    if (w_front_back == r_rear) begin
                        n_rear_val = r_value;
                    end
                end else begin
                    n_rear     = w_rear_fwd;
                    w_we       = 1'b1;
                    w_waddr    = w_rear_fwd;
                    n_rear_val = r_value;
                    if (w_rear_fwd == r_front) begin
                        n_front_val = r_value;
                    end
                end
            end
            MODE_POP_FRONT: begin
                if (r_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_removed = r_front_val;
                    if (r_front == r_rear) begin
                        n_empty = 1'b1;
                    end else begin
                        n_front     = w_front_fwd;
                        w_raddr     = w_front_fwd;
                        w_need_read = 1'b1;
                    end
                end
            end
            MODE_POP_REAR: begin
                if (r_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_removed = r_rear_val;
                    if (r_front == r_rear) begin
                        n_empty = 1'b1;
                    end else begin
                        n_rear      = w_rear_back;
                        w_raddr     = w_rear_back;
                        w_need_read = 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    assign o_stat.need_read = w_need_read;

    // Element store.
    cdq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.exec && w_we),
        .i_waddr(w_waddr),
        .i_wdata(r_value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Size register, indices and empty mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_RESET;
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_rear  <= n_rear;
                r_empty <= n_empty;
            end
        end
    end

    // Request latch, cached end elements and per-operation results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode  <= i_in_data.mode;
            r_value <= i_in_data.value;
        end
        if (i_cmd.exec) begin
            r_front_val <= n_front_val;
            r_rear_val  <= n_rear_val;
            r_status    <= n_status;
            r_removed   <= n_removed;
            r_pop_front <= (r_mode == MODE_POP_FRONT);
        end else if (i_cmd.read_done) begin
            // The element that became the new end after a pop.
            if (r_pop_front) begin
                r_front_val <= w_rdata;
            end else begin
                r_rear_val <= w_rdata;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status        <= r_status;
            r_out.removed_value <= r_removed;
            r_out.front_value   <= r_empty ? '0 : r_front_val;
            r_out.rear_value    <= r_empty ? '0 : r_rear_val;
            r_out.is_empty      <= r_empty;
            r_out.is_full       <= w_full;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== hw/rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a circular element store with push and pop at both
// ends, overflow and underflow refusal, and peek values in every result.
// ----------------------------------------------------------------------------
// Each request is handled on its own: the sequencer accepts it, updates the
// indices and writes the store, reads the store for a pop that leaves
// elements behind (the new end element comes out of the single read port of
// the store), then loads the result register. The result is presented in
// the cycle the next request can be accepted; the sequencer returns to
// accepting only after the result is loaded, so a result left waiting holds
// back the next request. The front and rear elements are kept in registers
// next to the store, so pushes and the removed value need no store read. The
// size register may be written only while no request is in flight; 0 acts
// as 1 and values above STORE_DEPTH act as STORE_DEPTH.
// ----------------------------------------------------------------------------
module circular_deque
    import cdq_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer.
    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Indices, store and result register.
    cdq_dpath #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (i_in_data),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_data   (o_out_data)
    );

endmodule
